/* rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One decoded request: one to three result bytes sharing a status.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      st;
    logic [2:0][7:0] bytes;
  } jsu_cmd_t;

endpackage

/* rtl/jsu_front.sv */
// Front end: accepts input bytes, tracks string state and builds result requests.
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_restart,
  input  logic              q_full,
  output logic              push,
  output jsu_pkg::jsu_cmd_t cmd
);
  import jsu_pkg::*;

  localparam logic [1:0] M_SEEK = 2'd0;
  localparam logic [1:0] M_STR  = 2'd1;
  localparam logic [1:0] M_ESC  = 2'd2;
  localparam logic [1:0] M_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  logic [1:0]  mode_r, mode_nxt, mode_e;
  logic [1:0]  hc_r, hc_nxt, hc_e;
  logic [15:0] cp_r, cp_nxt, cp_e;
  logic [15:0] cp_new;
  logic        hex_ok;
  logic [3:0]  hex_v;
  logic        fire;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_v = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_v = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_v = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign in_stall = q_full;
  assign fire     = in_valid && !in_stall;
  assign cp_new   = {cp_e[11:0], hex_v};

  always_comb begin
    mode_e   = in_restart ? M_SEEK : mode_r;
    hc_e     = in_restart ? 2'd0   : hc_r;
    cp_e     = in_restart ? 16'd0  : cp_r;
    mode_nxt = mode_e;
    hc_nxt   = hc_e;
    cp_nxt   = cp_e;
    cmd      = '0;
    cmd.st   = ST_DATA;
    unique case (mode_e)
      M_SEEK: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = M_STR;
        end else if (in_byte == 8'd0 || in_byte > CH_SPACE) begin
          cmd.cnt = 2'd1;
          cmd.st  = ST_ERR;
        end
      end
      M_STR: begin
        if (in_byte == 8'd0) begin
          cmd.cnt  = 2'd1;
          cmd.st   = ST_ERR;
          mode_nxt = M_SEEK;
        end else if (in_byte == CH_QUOTE) begin
          cmd.cnt  = 2'd1;
          cmd.st   = ST_DONE;
          mode_nxt = M_SEEK;
        end else if (in_byte == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          cmd.cnt      = 2'd1;
          cmd.bytes[0] = in_byte;
        end
      end
      M_ESC: begin
        if (in_byte == 8'd0) begin
          cmd.cnt  = 2'd1;
          cmd.st   = ST_ERR;
          mode_nxt = M_SEEK;
          hc_nxt   = 2'd0;
          cp_nxt   = 16'd0;
        end else if (in_byte == 8'h75) begin
          mode_nxt = M_HEX;
          hc_nxt   = 2'd0;
          cp_nxt   = 16'd0;
        end else begin
          cmd.cnt  = 2'd1;
          mode_nxt = M_STR;
          case (in_byte)
            8'h62:   cmd.bytes[0] = 8'h08;
            8'h66:   cmd.bytes[0] = 8'h0C;
            8'h6E:   cmd.bytes[0] = 8'h0A;
            8'h72:   cmd.bytes[0] = 8'h0D;
            8'h74:   cmd.bytes[0] = 8'h09;
            default: cmd.bytes[0] = in_byte;
          endcase
        end
      end
      M_HEX: begin
        if (!hex_ok) begin
          cmd.cnt  = 2'd1;
          cmd.st   = ST_ERR;
          mode_nxt = M_SEEK;
          hc_nxt   = 2'd0;
          cp_nxt   = 16'd0;
        end else if (hc_e == 2'd3) begin
          mode_nxt = M_STR;
          hc_nxt   = 2'd0;
          cp_nxt   = 16'd0;
          if (cp_new[15:7] == 9'd0) begin
            cmd.cnt      = 2'd1;
            cmd.bytes[0] = cp_new[7:0];
          end else if (cp_new[15:11] == 5'd0) begin
            cmd.cnt      = 2'd2;
            cmd.bytes[0] = {3'b110, cp_new[10:6]};
            cmd.bytes[1] = {2'b10, cp_new[5:0]};
          end else begin
            cmd.cnt      = 2'd3;
            cmd.bytes[0] = {4'b1110, cp_new[15:12]};
            cmd.bytes[1] = {2'b10, cp_new[11:6]};
            cmd.bytes[2] = {2'b10, cp_new[5:0]};
          end
        end else begin
          cp_nxt = cp_new;
          hc_nxt = hc_e + 2'd1;
        end
      end
      default: mode_nxt = M_SEEK;
    endcase
  end

  assign push = fire && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_SEEK;
      hc_r   <= 2'd0;
      cp_r   <= 16'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      hc_r   <= hc_nxt;
      cp_r   <= cp_nxt;
    end
  end

endmodule

/* rtl/jsu_queue.sv */
// Short request queue between the front end and the output sequencer.
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::jsu_cmd_t push_cmd,
  input  logic              pop,
  output jsu_pkg::jsu_cmd_t head,
  output logic              empty,
  output logic              full
);
  import jsu_pkg::*;

  jsu_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign empty = (cnt_r == QCNT_W'(0));
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/jsu_back.sv */
// Back end: walks the head request and delivers its result bytes one per cycle while the output is not stalled.
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::jsu_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_status,
  output logic              out_last
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid  = !empty;
  assign out_status = head.st;
  assign out_last   = (idx_r == head.cnt - 2'd1);
  assign fire       = out_valid && !out_stall;
  assign pop        = fire && out_last;

  always_comb begin
    case (idx_r)
      2'd1:    out_byte = head.bytes[1];
      2'd2:    out_byte = head.bytes[2];
      default: out_byte = head.bytes[0];
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

/* rtl/json_string_unescaper_top.sv */
// Top level of the JSON string unescaper: front end, request queue and output sequencer.
//
// Takes one byte per cycle while not stalled. Each byte is decoded in the cycle it is
// accepted and its results (none, one, or two to three UTF-8 bytes for a \u escape) go
// into a four-entry request queue; they are registered there and leave it one result
// per cycle while the output is not stalled. The output sequencer sets the drain rate:
// a request holds it until its last result is taken. The input stalls only when the
// queue is full. The queue can only fill while the output is stalled: a three-byte \u
// escape spends six input bytes, so the backlog it leaves drains before the next one
// is done. The stall comes from the registered fill count, so a full queue holds the
// input for that cycle even when a request leaves in the same cycle.
module json_string_unescaper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last
);
  import jsu_pkg::*;

  jsu_cmd_t push_cmd, head;
  logic     push, pop, q_empty, q_full;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_restart (in_restart),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  // completion and error are always single results
  a_ctl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DONE || out_status == ST_ERR) |-> out_last)
    else $error("status result not marked last");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request queue overflow");

  // a multi-byte request keeps the output busy until its last byte
  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_status == ST_DATA)
    else $error("multi-byte result broken off");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

/* tb/sv/tb_json_string_unescaper_top.sv */
`timescale 1ns / 1ps
// Testbench for the JSON string unescaper: directed and random byte streams against a scoreboard.

typedef struct packed {
  logic [7:0] data;
  logic [1:0] status;
  logic       last;
} unesc_result_t;

class unescape_scoreboard;
  typedef enum logic [1:0] {SEEK, IN_STR, AFTER_BSL, IN_HEX} scan_mode_e;

  scan_mode_e    scan_mode;
  logic [1:0]    hex_cnt;
  logic [15:0]   code_acc;
  unesc_result_t step_q[$];
  unesc_result_t expected_q[$];
  int            n_mismatch;

  function new();
    drop_string();
    n_mismatch = 0;
  endfunction

  static function int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function void drop_string();
    scan_mode = SEEK;
    hex_cnt   = '0;
    code_acc  = '0;
  endfunction

  function void emit(logic [7:0] d, logic [1:0] st);
    unesc_result_t r;
    r.data   = d;
    r.status = st;
    r.last   = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  // Work out the results of one accepted request and queue them.
  function void note_request(logic [7:0] b, logic rs);
    unesc_result_t r;
    logic [15:0]   cp;
    int            h;
    if (rs) drop_string();
    case (scan_mode)
      SEEK: begin
        if (b == "\"") begin
          scan_mode = IN_STR;
        end else if (b == 8'd0 || b > 8'd32) begin
          emit(8'd0, jsu_pkg::ST_ERR);
          drop_string();
        end
      end
      IN_STR: begin
        if (b == 8'd0) begin
          emit(8'd0, jsu_pkg::ST_ERR);
          drop_string();
        end else if (b == "\"") begin
          emit(8'd0, jsu_pkg::ST_DONE);
          drop_string();
        end else if (b == "\\") begin
          scan_mode = AFTER_BSL;
        end else begin
          emit(b, jsu_pkg::ST_DATA);
        end
      end
      AFTER_BSL: begin
        if (b == 8'd0) begin
          emit(8'd0, jsu_pkg::ST_ERR);
          drop_string();
        end else if (b == "u") begin
          scan_mode = IN_HEX;
          hex_cnt   = '0;
          code_acc  = '0;
        end else begin
          case (b)
            "b":     emit(8'h08, jsu_pkg::ST_DATA);
            "f":     emit(8'h0C, jsu_pkg::ST_DATA);
            "n":     emit(8'h0A, jsu_pkg::ST_DATA);
            "r":     emit(8'h0D, jsu_pkg::ST_DATA);
            "t":     emit(8'h09, jsu_pkg::ST_DATA);
            default: emit(b, jsu_pkg::ST_DATA);
          endcase
          scan_mode = IN_STR;
        end
      end
      default: begin
        h = hex_val(b);
        if (h < 0) begin
          emit(8'd0, jsu_pkg::ST_ERR);
          drop_string();
        end else begin
          cp = {code_acc[11:0], h[3:0]};
          if (hex_cnt == 2'd3) begin
            // code point complete: UTF-8 encode, no surrogate pairing
            if (cp < 16'h0080) begin
              emit(cp[7:0], jsu_pkg::ST_DATA);
            end else if (cp < 16'h0800) begin
              emit(8'hC0 | cp[10:6], jsu_pkg::ST_DATA);
              emit(8'h80 | cp[5:0], jsu_pkg::ST_DATA);
            end else begin
              emit(8'hE0 | cp[15:12], jsu_pkg::ST_DATA);
              emit(8'h80 | cp[11:6], jsu_pkg::ST_DATA);
              emit(8'h80 | cp[5:0], jsu_pkg::ST_DATA);
            end
            scan_mode = IN_STR;
            hex_cnt   = '0;
            code_acc  = '0;
          end else begin
            code_acc = cp;
            hex_cnt  = hex_cnt + 2'd1;
          end
        end
      end
    endcase
    foreach (step_q[i]) begin
      r      = step_q[i];
      r.last = (i == step_q.size() - 1);
      expected_q.insert(expected_q.size(), r);
    end
    step_q.delete();
  endfunction

  function void check_result(logic [7:0] d, logic [1:0] st, logic lst);
    unesc_result_t want;
    if (expected_q.size() == 0) begin
      n_mismatch++;
      $display("%0t: unexpected result byte=%02h status=%0d last=%0b", $time, d, st, lst);
      return;
    end
    want = expected_q.pop_front();
    if (want.data !== d || want.status !== st || want.last !== lst) begin
      n_mismatch++;
      $display("%0t: expected byte=%02h status=%0d last=%0b, got byte=%02h status=%0d last=%0b",
               $time, want.data, want.status, want.last, d, st, lst);
    end
  endfunction
endclass

module tb_json_string_unescaper_top;
  import jsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          N_RANDOM    = 230;

  typedef struct {
    logic [7:0] b;
    logic       rs;
  } text_byte_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       in_restart = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last;

  unescape_scoreboard sb = new();
  text_byte_t         text_q[$];
  bit                 rand_restart_en = 1'b0;
  int                 burst_left = 0;
  int unsigned        cycle_cnt = 0;
  stall_style_e       stall_style = STALL_NONE;
  int                 stall_phase_left = 0;
  int                 stall_run = 0;

  json_string_unescaper_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_byte, out_status, out_last);
  end

  // Receiver: alternates between no stall, random stall and long stall runs.
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_style      = stall_style_e'($urandom_range(0, 2));
      stall_phase_left = $urandom_range(20, 120);
    end
    stall_phase_left--;
    case (stall_style)
      STALL_NONE:   out_stall = 1'b0;
      STALL_RANDOM: out_stall = ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0) begin
          out_stall = ~out_stall;
          stall_run = out_stall ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        stall_run--;
      end
    endcase
  end

  task automatic put_byte(input logic [7:0] b, input logic rs = 1'b0);
    text_byte_t t;
    t.b  = b;
    t.rs = rs | (rand_restart_en && $urandom_range(0, 49) == 0);
    text_q.insert(text_q.size(), t);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
  endfunction

  task automatic put_hex(input logic [15:0] cp, input int n_digits);
    for (int i = 3; i > 3 - n_digits; i--) put_byte(hex_char(cp[i*4 +: 4]));
  endtask

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 6))
          0:       return 16'h007F;
          1:       return 16'h0080;
          2:       return 16'h07FF;
          3:       return 16'h0800;
          4:       return 16'hD800;
          5:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // One element of string content: plain byte, short escape or \u escape.
  task automatic put_piece();
    logic [7:0] b;
    int         k;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      do b = 8'($urandom_range(1, 255)); while (b == "\"" || b == "\\");
      put_byte(b);
    end else if (k < 8) begin
      put_byte("\\");
      case ($urandom_range(0, 8))
        0: put_byte("b");
        1: put_byte("f");
        2: put_byte("n");
        3: put_byte("r");
        4: put_byte("t");
        5: put_byte("\"");
        6: put_byte("\\");
        7: put_byte("/");
        default: begin
          do b = 8'($urandom_range(1, 255)); while (b == "u");
          put_byte(b);
        end
      endcase
    end else begin
      put_byte("\\");
      put_byte("u");
      put_hex(pick_code_point(), 4);
    end
  endtask

  task automatic put_good_string();
    repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(1, 32)));
    put_byte("\"");
    repeat ($urandom_range(0, 8)) put_piece();
    put_byte("\"");
  endtask

  task automatic put_broken_string();
    logic [7:0] b;
    put_byte("\"");
    repeat ($urandom_range(0, 4)) put_piece();
    case ($urandom_range(0, 4))
      0: put_byte(8'd0);
      1: begin
        put_byte("\\");
        put_byte(8'd0);
      end
      2: begin
        put_byte("\\");
        put_byte("u");
        put_hex(pick_code_point(), $urandom_range(0, 3));
        put_byte(8'd0);
      end
      3: begin
        put_byte("\\");
        put_byte("u");
        put_hex(pick_code_point(), $urandom_range(0, 3));
        do b = 8'($urandom_range(0, 255)); while (sb.hex_val(b) >= 0);
        put_byte(b);
      end
      default: put_byte(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_text();
    text_byte_t t;
    int         gap;
    while (text_q.size() != 0) begin
      t = text_q.pop_front();
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      @(negedge clk);
      in_valid   = 1'b1;
      in_byte    = t.b;
      in_restart = t.rs;
      do @(posedge clk); while (in_stall);
      sb.note_request(t.b, t.rs);
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: skipped whitespace, seek errors, 3-byte and zero \u, unknown escape,
    // completion, restart on a quote, truncation by a zero byte
    put_byte(8'h20);
    put_byte(8'h01);
    put_byte("x");
    put_byte(8'h00);
    put_byte("\"");
    put_byte(8'hFF);
    put_byte("\\");
    put_byte("u");
    put_byte("F");
    put_byte("f");
    put_byte("A");
    put_byte("a");
    put_byte("\\");
    put_byte("u");
    repeat (4) put_byte("0");
    put_byte("\\");
    put_byte("q");
    put_byte("\"");
    put_byte("\"");
    put_byte("a");
    put_byte("\"", 1'b1);
    put_byte(8'h00);
    send_text();
    wait_drain();

    rand_restart_en = 1'b1;
    while (text_q.size() < N_RANDOM) begin
      case ($urandom_range(0, 19))
        16, 17, 18: put_broken_string();
        19:         repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        default:    put_good_string();
      endcase
    end
    send_text();
    wait_drain();
    repeat (20) @(posedge clk);

    if (sb.n_mismatch == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
